>>> hdl/spli_pkg.sv
// Shared types and codes for the stereo sample player.
// No dependencies; imported by sample_player_linear_interp_top.
`timescale 1ns / 1ps

package spli_pkg;

  // sample_length register width
  localparam int LEN_BITS = 17;
  // input and output channel field width
  localparam int CHAN_BITS = 16;
  // phase register width
  localparam int PHASE_BITS = 32;
  // step field width
  localparam int STEP_BITS = 20;
  // write address field width
  localparam int ADDR_BITS = 16;
  // configuration index width
  localparam int CFG_IDX_BITS = 1;

  typedef logic [LEN_BITS-1:0]   len_t;
  typedef logic [PHASE_BITS-1:0] phase_t;

  // request types
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_LENGTH = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOOP   = 1'b1;

endpackage

>>> hdl/sample_player_linear_interp_top.sv
// Stereo sample player: frame memory, phase accumulator, linear interpolation.
// Depends on spli_pkg.
// A tick beat passes the frame-read, multiply and output registers.
// Throughput: one beat per cycle unless the output stalls; write beats use the
// single write port and tick beats the two read ports of the frame memory, so
// both sustain one a cycle. Reset clears phase, ended flag, length, pipeline
// valids, sets looping on; the frame memory is not cleared, empty until written.
`timescale 1ns / 1ps

module sample_player_linear_interp_top
  import spli_pkg::*;
#(
  parameter int MEM_FRAMES  = 65536,
  parameter int FRAC_BITS   = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wen,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [LEN_BITS-1:0]     cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    req_type,
  input  logic [ADDR_BITS-1:0]    write_addr,
  input  logic [CHAN_BITS-1:0]    write_left,
  input  logic [CHAN_BITS-1:0]    write_right,
  input  logic [STEP_BITS-1:0]    step,
  input  logic                    gate,
  input  logic                    note_on,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [CHAN_BITS-1:0]    left_out,
  output logic [CHAN_BITS-1:0]    right_out
);

  localparam int AW  = (MEM_FRAMES > 1) ? $clog2(MEM_FRAMES) : 1;
  localparam int SB  = SAMPLE_BITS;
  localparam int KB  = (SAMPLE_BITS < CHAN_BITS) ? SAMPLE_BITS : CHAN_BITS;
  localparam int NPW = (((LEN_BITS + FRAC_BITS) > (PHASE_BITS + 1)) ?
                        (LEN_BITS + FRAC_BITS) : (PHASE_BITS + 1)) + 1;
  localparam int PW  = SB + FRAC_BITS + 2;
  localparam logic [31:0] MEM_FRAMES_W = 32'(MEM_FRAMES);
  localparam logic [47:0] MEM_FRAMES_X = 48'(MEM_FRAMES);

  // configuration
  len_t sample_length;
  logic loop_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_length <= '0;
      loop_enable   <= 1'b1;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_LENGTH: sample_length <= cfg_wdata;
        CFG_LOOP:   loop_enable   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // frame memory, right in the upper half
  logic [2*SB-1:0] mem [MEM_FRAMES];

  // pipeline control
  logic en1, en2, en3;
  logic v1, v2;
  logic live1, live2;
  logic [FRAC_BITS-1:0] frac1;
  logic [2*SB-1:0] rd_a, rd_b;
  logic signed [SB-1:0] a2_l, a2_r;
  logic signed [PW-1:0] prod2_l, prod2_r;

  assign en3      = !out_valid || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  logic in_acc, wr_acc, tick_acc;
  assign in_acc   = in_valid && in_ready;
  assign wr_acc   = in_acc && (req_type == REQ_WRITE);
  assign tick_acc = in_acc && (req_type == REQ_TICK);

  // write path
  logic [47:0]   waddr_x;
  logic [AW-1:0] waddr;
  logic          waddr_ok;
  logic [SB-1:0] wl, wr;

  assign waddr_x  = 48'(write_addr);
  assign waddr    = waddr_x[AW-1:0];
  assign waddr_ok = waddr_x < MEM_FRAMES_X;
  assign wl       = SB'(write_left[KB-1:0]);
  assign wr       = SB'(write_right[KB-1:0]);

  always_ff @(posedge clk) begin
    if (wr_acc && waddr_ok) begin
      mem[waddr] <= {wr, wl};
    end
  end

  // phase state and next phase
  phase_t play_phase;
  logic   ended_flag;
  len_t   len_cap;
  logic   restart, end0, silent, in_range, past_end;
  phase_t ph0;
  logic [NPW-1:0] ph_x, idx_x, nxt_x, np, np_wrap, len_x;
  logic [AW-1:0]  addr_a, addr_b;
  phase_t phase_next;
  logic   ended_next;

  always_comb begin
    len_cap = (32'(sample_length) > MEM_FRAMES_W) ? MEM_FRAMES_W[LEN_BITS-1:0]
                                                  : sample_length;
    restart  = note_on && ended_flag;
    ph0      = restart ? '0 : play_phase;
    end0     = restart ? 1'b0 : ended_flag;
    silent   = !gate || (len_cap == '0) || end0;
    len_x    = NPW'(len_cap);
    ph_x     = NPW'(ph0);
    idx_x    = ph_x >> FRAC_BITS;
    in_range = idx_x < len_x;
    nxt_x    = ((idx_x + NPW'(1)) >= len_x) ? '0 : (idx_x + NPW'(1));
    addr_a   = idx_x[AW-1:0];
    addr_b   = nxt_x[AW-1:0];
    np       = ph_x + NPW'(step);
    np_wrap  = np - (len_x << FRAC_BITS);
    past_end = (np >> FRAC_BITS) >= len_x;
    phase_next = ph0;
    ended_next = end0;
    if (!silent) begin
      if (past_end && loop_enable) begin
        phase_next = np_wrap[PHASE_BITS-1:0];
      end else begin
        phase_next = np[PHASE_BITS-1:0];
      end
      if (past_end && !loop_enable) begin
        ended_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      play_phase <= '0;
      ended_flag <= 1'b0;
    end else if (tick_acc) begin
      play_phase <= phase_next;
      ended_flag <= ended_next;
    end
  end

  // stage 1: frame reads
  always_ff @(posedge clk) begin
    if (en1 && tick_acc) begin
      rd_a  <= mem[addr_a];
      rd_b  <= mem[addr_b];
      frac1 <= ph0[FRAC_BITS-1:0];
      live1 <= !silent && in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= tick_acc;
    end
  end

  // stage 2: difference times fraction
  logic signed [SB-1:0]        a_l, a_r, b_l, b_r;
  logic signed [SB:0]          d_l, d_r;
  logic signed [FRAC_BITS:0]   f_s;

  always_comb begin
    a_l = $signed(rd_a[SB-1:0]);
    a_r = $signed(rd_a[2*SB-1:SB]);
    b_l = $signed(rd_b[SB-1:0]);
    b_r = $signed(rd_b[2*SB-1:SB]);
    d_l = (SB+1)'(b_l) - (SB+1)'(a_l);
    d_r = (SB+1)'(b_r) - (SB+1)'(a_r);
    f_s = $signed({1'b0, frac1});
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      a2_l    <= a_l;
      a2_r    <= a_r;
      prod2_l <= PW'(d_l) * PW'(f_s);
      prod2_r <= PW'(d_r) * PW'(f_s);
      live2   <= live1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  // stage 3: floor shift, add base, output register
  logic signed [PW-1:0] sum_l, sum_r;

  always_comb begin
    sum_l = (prod2_l >>> FRAC_BITS) + PW'(a2_l);
    sum_r = (prod2_r >>> FRAC_BITS) + PW'(a2_r);
  end

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      left_out  <= live2 ? CHAN_BITS'(sum_l[KB-1:0]) : '0;
      right_out <= live2 ? CHAN_BITS'(sum_r[KB-1:0]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en3) begin
      out_valid <= v2;
    end
  end

  // checks
  a_end_needs_no_loop: assert property (@(posedge clk) disable iff (rst)
    $rose(ended_flag) |-> $past(!loop_enable))
    else $error("ended flag set while looping");

  a_silent_zero: assert property (@(posedge clk) disable iff (rst)
    (en3 && v2 && !live2) |=> (left_out == '0 && right_out == '0))
    else $error("silent beat gave nonzero output");

  a_write_holds_phase: assert property (@(posedge clk) disable iff (rst)
    wr_acc |=> ($stable(play_phase) && $stable(ended_flag)))
    else $error("write beat moved the phase");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    (!v1 && !v2 && !out_valid) |-> in_ready)
    else $error("empty pipeline not ready");

endmodule

>>> dv/tb_sample_player_linear_interp_top.sv
// Self-checking testbench for sample_player_linear_interp_top: directed and random
// write/tick beats, random valid and ready idling, outputs checked against a predictor.
// Depends on spli_pkg and the sample_player_linear_interp_top RTL.
`timescale 1ns / 1ps

module tb_sample_player_linear_interp_top;
  import spli_pkg::*;

  localparam int MEM_FRAMES   = 65536;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 8000000;

  typedef struct packed {
    logic                 req;
    logic [ADDR_BITS-1:0] addr;
    logic [CHAN_BITS-1:0] wleft;
    logic [CHAN_BITS-1:0] wright;
    logic [STEP_BITS-1:0] step;
    logic                 gate;
    logic                 note_on;
  } beat_t;

  typedef struct packed {
    logic [CHAN_BITS-1:0] l;
    logic [CHAN_BITS-1:0] r;
  } stereo_t;

  class stereo_scoreboard;
    logic [31:0] frames [MEM_FRAMES];
    bit          written [MEM_FRAMES];
    phase_t      phase;
    bit          ended;
    len_t        length;
    bit          looping;
    stereo_t     queued[$];
    int          errors;

    function new();
      phase = '0;
      ended = 1'b0;
      length = '0;
      looping = 1'b1;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, len_t value);
      if (idx == CFG_LENGTH) begin
        length = value;
      end else if (idx == CFG_LOOP) begin
        looping = value[0];
      end
    endfunction

    function len_t active_len();
      return (length > len_t'(MEM_FRAMES)) ? len_t'(MEM_FRAMES) : length;
    endfunction

    // Frames a tick with these controls would interpolate between, if any.
    function void frames_read(logic g, logic nt, output bit rd,
                              output logic [15:0] fa, output logic [15:0] fb);
      phase_t      ph;
      bit          stopped;
      len_t        len;
      logic [16:0] idx;
      logic [16:0] nxt;
      ph = (nt && ended) ? '0 : phase;
      stopped = ended && !nt;
      len = active_len();
      idx = {1'b0, ph[31:16]};
      nxt = ((idx + 17'd1) >= len) ? '0 : (idx + 17'd1);
      rd = g && (len != 0) && !stopped && (idx < len);
      fa = idx[15:0];
      fb = nxt[15:0];
    endfunction

    function logic [15:0] blend(logic [15:0] a, logic [15:0] b, logic [15:0] f);
      longint va;
      longint vb;
      longint prod;
      va = longint'($signed(a));
      vb = longint'($signed(b));
      prod = (vb - va) * longint'(f);
      return 16'(va + (prod >>> 16));
    endfunction

    function void apply_beat(beat_t b);
      stereo_t     o;
      bit          rd;
      logic [15:0] fa;
      logic [15:0] fb;
      len_t        len;
      logic [33:0] np;
      if (b.req == REQ_WRITE) begin
        frames[b.addr] = {b.wright, b.wleft};
        written[b.addr] = 1'b1;
        return;
      end
      frames_read(b.gate, b.note_on, rd, fa, fb);
      if (b.note_on && ended) begin
        phase = '0;
        ended = 1'b0;
      end
      len = active_len();
      o = '0;
      if (b.gate && len != 0 && !ended) begin
        if (rd) begin
          o.l = blend(frames[fa][15:0], frames[fb][15:0], phase[15:0]);
          o.r = blend(frames[fa][31:16], frames[fb][31:16], phase[15:0]);
        end
        np = {2'b00, phase} + 34'(b.step);
        if (np[33:16] >= {1'b0, len}) begin
          if (looping) begin
            np = np - ({17'b0, len} << 16);
          end else begin
            ended = 1'b1;
          end
        end
        phase = np[31:0];
      end
      queued.push_back(o);
    endfunction

    function void check_output(logic [15:0] l, logic [15:0] r);
      stereo_t e;
      if (queued.size() == 0) begin
        $error("output beat with no tick pending: left_out=%0d right_out=%0d",
               $signed(l), $signed(r));
        errors++;
        return;
      end
      e = queued.pop_front();
      if (l !== e.l) begin
        $error("left_out: expected %0d, got %0d", $signed(e.l), $signed(l));
        errors++;
      end
      if (r !== e.r) begin
        $error("right_out: expected %0d, got %0d", $signed(e.r), $signed(r));
        errors++;
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_wen = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [LEN_BITS-1:0]     cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    req_type = 1'b0;
  logic [ADDR_BITS-1:0]    write_addr = '0;
  logic [CHAN_BITS-1:0]    write_left = '0;
  logic [CHAN_BITS-1:0]    write_right = '0;
  logic [STEP_BITS-1:0]    step = '0;
  logic                    gate = 1'b0;
  logic                    note_on = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [CHAN_BITS-1:0]    left_out;
  logic [CHAN_BITS-1:0]    right_out;

  bit                      in_steady = 1'b0;
  int                      cycle_count = 0;
  stereo_scoreboard        sb = new();

  sample_player_linear_interp_top DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .write_addr (write_addr),
    .write_left (write_left),
    .write_right(write_right),
    .step       (step),
    .gate       (gate),
    .note_on    (note_on),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .left_out   (left_out),
    .right_out  (right_out)
  );

  always #5 clk = ~clk;

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 64);
  endfunction

  function automatic beat_t random_beat();
    beat_t b;
    b.req = REQ_TICK;
    b.addr = ADDR_BITS'($urandom);
    b.wleft = CHAN_BITS'($urandom);
    b.wright = CHAN_BITS'($urandom);
    b.step = STEP_BITS'($urandom);
    b.gate = 1'($urandom);
    b.note_on = 1'($urandom);
    return b;
  endfunction

  task automatic send_beat(beat_t b);
    int gap;
    gap = in_steady ? 0 : idle_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    req_type <= b.req;
    write_addr <= b.addr;
    write_left <= b.wleft;
    write_right <= b.wright;
    step <= b.step;
    gate <= b.gate;
    note_on <= b.note_on;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.apply_beat(b);
  endtask

  task automatic write_frame(logic [15:0] addr, logic [15:0] lv, logic [15:0] rv);
    beat_t b;
    b = random_beat();
    b.req = REQ_WRITE;
    b.addr = addr;
    b.wleft = lv;
    b.wright = rv;
    send_beat(b);
  endtask

  // Load any frame the tick would read that holds no data yet, then send the tick.
  task automatic play_tick(logic [STEP_BITS-1:0] st, logic g, logic nt);
    beat_t       b;
    bit          rd;
    logic [15:0] fa;
    logic [15:0] fb;
    sb.frames_read(g, nt, rd, fa, fb);
    if (rd && !sb.written[fa]) write_frame(fa, 16'($urandom), 16'($urandom));
    if (rd && !sb.written[fb]) write_frame(fb, 16'($urandom), 16'($urandom));
    b = random_beat();
    b.req = REQ_TICK;
    b.step = st;
    b.gate = g;
    b.note_on = nt;
    send_beat(b);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.queued.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, len_t value);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wen <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  task automatic random_item();
    int                   span;
    logic [STEP_BITS-1:0] st;
    logic                 nt;
    span = (sb.active_len() == 0) ? 64 : int'(sb.active_len());
    if ($urandom_range(0, 99) < 15) begin
      if ($urandom_range(0, 3) == 0) begin
        write_frame(16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        write_frame(16'($urandom_range(0, span - 1)), 16'($urandom), 16'($urandom));
      end
    end else begin
      case ($urandom_range(0, 9))
        0: st = '0;
        1: st = '1;
        2: st = 20'h10000;
        3, 4: st = STEP_BITS'($urandom);
        5, 6: st = STEP_BITS'($urandom_range(1, 20'h1FFFF));
        default: st = STEP_BITS'($urandom_range(1, 16'hFFFF));
      endcase
      nt = sb.ended ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 19) == 0);
      play_tick(st, $urandom_range(0, 9) != 0, nt);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_output(left_out, right_out);
  end

  initial begin
    int span;
    forever begin
      span = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
      @(negedge clk);
      out_ready <= 1'b1;
      repeat (span) @(negedge clk);
      span = idle_gap();
      if (span > 0) begin
        out_ready <= 1'b0;
        repeat (span) @(negedge clk);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    len_t        len_sel;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // nothing loaded: silent
    play_tick(20'h10000, 1'b1, 1'b0);
    settle();
    write_reg(CFG_LENGTH, len_t'(2));
    write_frame(16'h0000, 16'h7FFF, 16'h8000);
    write_frame(16'h0001, 16'h8000, 16'h7FFF);
    write_frame(16'hFFFF, 16'h8000, 16'h7FFF);
    play_tick(20'h08000, 1'b1, 1'b0);
    play_tick(20'h0FFFF, 1'b1, 1'b0);
    play_tick(20'h00000, 1'b0, 1'b1);
    play_tick(20'h10000, 1'b1, 1'b0);
    play_tick(20'hFFFFF, 1'b1, 1'b0);
    play_tick(20'h00000, 1'b1, 1'b0);
    play_tick(20'h00001, 1'b1, 1'b0);
    // stop at end, then restart with note-on
    settle();
    write_reg(CFG_LOOP, len_t'(0));
    repeat (3) play_tick(20'h18000, 1'b1, 1'b0);
    play_tick(20'h04000, 1'b1, 1'b1);
    play_tick(20'h04000, 1'b1, 1'b1);
    settle();
    write_reg(CFG_LENGTH, len_t'(1));
    repeat (3) play_tick(20'h0C000, 1'b1, 1'b1);
    settle();
    write_reg(CFG_LENGTH, 17'h1FFFF);
    write_reg(CFG_LOOP, len_t'(1));
    play_tick(20'hFFFFF, 1'b1, 1'b1);
    play_tick(20'hFFFFF, 1'b1, 1'b0);

    for (int p = 0; p < 10; p++) begin
      settle();
      case ($urandom_range(0, 9))
        0: len_sel = '0;
        1: len_sel = len_t'(1);
        2: len_sel = len_t'(2);
        3: len_sel = len_t'(MEM_FRAMES);
        4: len_sel = len_t'($urandom_range(MEM_FRAMES + 1, 131071));
        5: len_sel = len_t'($urandom_range(3, 300));
        default: len_sel = len_t'($urandom_range(2, 24));
      endcase
      write_reg(CFG_LENGTH, len_sel);
      write_reg(CFG_LOOP, len_t'({$urandom, 1'($urandom_range(0, 9) < 6)}));
      in_steady = ($urandom_range(0, 3) == 0);
      repeat (100) random_item();
    end

    settle();
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/spli_pkg.sv
hdl/sample_player_linear_interp_top.sv
dv/tb_sample_player_linear_interp_top.sv
